FILE: hw/rtl/fat12_cluster_chain_reader_core_assert.svh
// Assertion macros shared by the FAT12 chain reader RTL.
// Needs nothing else; included by the files that carry checks.
`ifndef FAT12_CLUSTER_CHAIN_READER_CORE_ASSERT_SVH
`define FAT12_CLUSTER_CHAIN_READER_CORE_ASSERT_SVH

// Same-cycle implication check.
`define FCR_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fat12 chain reader check failed");

// Next-cycle implication check.
`define FCR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fat12 chain reader check failed");

`endif

FILE: hw/rtl/fcr_pkg.sv
// Shared types and constants of the FAT12 chain reader.
// No dependencies; imported by the controller, the datapath and the top level.
package fcr_pkg;

   localparam int TABLE_BYTES_DEF = 8192;

   // field widths
   localparam int BPS_W      = 13;
   localparam int SPC_W      = 8;
   localparam int RSV_W      = 16;
   localparam int COPIES_W   = 8;
   localparam int FATSZ_W    = 16;
   localparam int ROOTENT_W  = 16;
   localparam int CLUSTER_W  = 12;
   localparam int COUNT_W    = 32;
   localparam int OFFSET_W   = 32;
   localparam int LEN_W      = 21;
   localparam int INDEX_W    = 13;
   localparam int BYTE_W     = 8;
   localparam int CB_W       = SPC_W + BPS_W;
   localparam int DIV_NUM_W  = 22;

   // stream packing
   localparam int OP_W        = 2;
   localparam int REQ_TDATA_W = 72;
   localparam int RSP_TDATA_W = 88;
   localparam int RSP_TUSER_W = 2;

   // register file
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_BPS     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPC     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_RSV     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_COPIES  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_FATSZ   = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROOTENT = 3'd5;

   localparam logic [BPS_W-1:0]     BPS_RST     = 13'd512;
   localparam logic [SPC_W-1:0]     SPC_RST     = 8'd1;
   localparam logic [RSV_W-1:0]     RSV_RST     = 16'd1;
   localparam logic [COPIES_W-1:0]  COPIES_RST  = 8'd2;
   localparam logic [FATSZ_W-1:0]   FATSZ_RST   = 16'd9;
   localparam logic [ROOTENT_W-1:0] ROOTENT_RST = 16'd224;

   // table entry at or above this ends the chain; equal means bad cluster
   localparam logic [CLUSTER_W-1:0] ENTRY_BAD = 12'hFF7;

   typedef enum logic [OP_W-1:0] {
      OP_LOAD  = 2'd0,
      OP_START = 2'd1,
      OP_NEXT  = 2'd2,
      OP_NONE  = 2'd3
   } fcr_op_type;

   typedef enum logic [1:0] {
      RES_ZERO,
      RES_ROOT,
      RES_CHAIN
   } fcr_res_type;

   typedef struct packed {
      logic        calc_prep;
      logic        calc_area;
      logic        calc_scale;
      logic        calc_data;
      logic        table_write;
      logic        chain_start;
      logic        look;
      logic        emit;
      fcr_res_type kind;
   } fcr_cmd_type;

   typedef struct packed {
      fcr_op_type op;
      logic       start_zero;
      logic       active;
      logic       div_done;
      logic       out_free;
   } fcr_status_type;

endpackage

FILE: hw/rtl/fcr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the allocation table banks.
module fcr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/fcr_div.sv
// Restoring divider, one quotient bit per cycle.
// No dependencies; used by the datapath for the root directory sector count.
module fcr_div #(
   parameter int NUM_W = 22,
   parameter int DEN_W = 13
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] dividend,
   input  logic [DEN_W-1:0] divisor,
   output logic             done,
   output logic [NUM_W-1:0] quotient
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] num_ff;
   logic [DEN_W-1:0] rem_ff;
   logic [DEN_W-1:0] den_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;
   logic             done_ff;
   logic [DEN_W:0]   trial;
   logic [DEN_W:0]   diff;
   logic             fits;

   assign trial = {rem_ff, num_ff[NUM_W-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign fits  = !diff[DEN_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            num_ff  <= dividend;
            rem_ff  <= '0;
            den_ff  <= divisor;
            cnt_ff  <= '0;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            // quotient bits shift in where dividend bits leave
            rem_ff <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            num_ff <= {num_ff[NUM_W-2:0], fits};
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(NUM_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = num_ff;

endmodule

FILE: hw/rtl/fcr_ctrl.sv
// Controller of the FAT12 chain reader: sequences geometry recalculation,
// request decode, table lookup and result emission. Uses fcr_pkg.
`include "fat12_cluster_chain_reader_core_assert.svh"

module fcr_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic                   csr_write,
   input  fcr_pkg::fcr_status_type st,
   output fcr_pkg::fcr_cmd_type    cmd
);

   import fcr_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_PREP,
      S_AREA,
      S_DIV,
      S_SCALE,
      S_DATA,
      S_LOOK,
      S_EMIT
   } state_type;

   state_type   state_ff, state_in;
   logic        dirty_ff, dirty_in;
   fcr_res_type kind_ff, kind_in;
   logic        accept;

   assign req_tready = (state_ff == S_IDLE) && !dirty_ff;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      state_in = state_ff;
      kind_in  = kind_ff;
      cmd      = '0;
      cmd.kind = kind_ff;
      // any register write forces a fresh pass over the derived geometry
      dirty_in = csr_write ? 1'b1 : ((state_ff == S_PREP) ? 1'b0 : dirty_ff);
      unique case (state_ff)
         S_IDLE: begin
            if (dirty_ff) begin
               state_in = S_PREP;
            end else if (accept) begin
               state_in = S_EMIT;
               kind_in  = RES_ZERO;
               unique case (st.op)
                  OP_LOAD: begin
                     cmd.table_write = 1'b1;
                  end
                  OP_START: begin
                     if (st.start_zero) begin
                        kind_in = RES_ROOT;
                     end else begin
                        cmd.chain_start = 1'b1;
                        kind_in         = RES_CHAIN;
                        state_in        = S_LOOK;
                     end
                  end
                  OP_NEXT: begin
                     if (st.active) begin
                        kind_in  = RES_CHAIN;
                        state_in = S_LOOK;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_PREP: begin
            cmd.calc_prep = 1'b1;
            state_in      = S_AREA;
         end
         S_AREA: begin
            cmd.calc_area = 1'b1;
            state_in      = S_DIV;
         end
         S_DIV: begin
            if (st.div_done) begin
               state_in = S_SCALE;
            end
         end
         S_SCALE: begin
            cmd.calc_scale = 1'b1;
            state_in       = S_DATA;
         end
         S_DATA: begin
            cmd.calc_data = 1'b1;
            state_in      = S_IDLE;
         end
         S_LOOK: begin
            cmd.look = 1'b1;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            // hold until the output register can take the result
            if (st.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         dirty_ff <= 1'b1;
         kind_ff  <= RES_ZERO;
      end else begin
         state_ff <= state_in;
         dirty_ff <= dirty_in;
         kind_ff  <= kind_in;
      end
   end

   `FCR_ASSERT_NEXT(a_look_then_emit, clock, reset, state_ff == S_LOOK, state_ff == S_EMIT)
   `FCR_ASSERT_NOW(a_look_needs_chain, clock, reset, state_ff == S_LOOK, st.active)
   `FCR_ASSERT_NOW(a_div_done_in_wait, clock, reset, st.div_done, state_ff == S_DIV)

endmodule

FILE: hw/rtl/fcr_dp.sv
// Datapath of the FAT12 chain reader: registers, geometry arithmetic,
// banked table store, chain state and output register. Uses fcr_pkg,
// fcr_div and fcr_ram.
module fcr_dp #(
   parameter int TABLE_BYTES = fcr_pkg::TABLE_BYTES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  fcr_pkg::fcr_cmd_type              cmd,
   output fcr_pkg::fcr_status_type           st,
   input  logic [fcr_pkg::OP_W-1:0]          opcode,
   input  logic [fcr_pkg::INDEX_W-1:0]       table_byte_index,
   input  logic [fcr_pkg::BYTE_W-1:0]        table_byte_value,
   input  logic [fcr_pkg::CLUSTER_W-1:0]     start_cluster,
   input  logic [fcr_pkg::COUNT_W-1:0]       byte_count,
   input  logic                              csr_write,
   input  logic [fcr_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [fcr_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  logic                              rsp_ready,
   output logic                              rsp_valid,
   output logic                              request_valid,
   output logic [fcr_pkg::OFFSET_W-1:0]      device_offset,
   output logic [fcr_pkg::LEN_W-1:0]         read_length,
   output logic [fcr_pkg::OFFSET_W-1:0]      dest_offset,
   output logic                              last,
   output logic                              bad_cluster
);

   import fcr_pkg::*;

   localparam int BANK_DEPTH = (TABLE_BYTES + 1) / 2;
   localparam int BAW        = $clog2(BANK_DEPTH);
   localparam int FPROD_W    = COPIES_W + FATSZ_W;
   localparam int AREA_W     = FPROD_W + 1;
   localparam int DSUM_W     = AREA_W + 1;
   localparam int ROOTP_W    = AREA_W + BPS_W;
   localparam int DATAP_W    = DSUM_W + BPS_W;
   localparam int CREL_W     = CLUSTER_W + 1;
   localparam int CPROD_W    = CREL_W + CB_W + 1;

   // configuration registers
   logic [BPS_W-1:0]     bps_ff;
   logic [SPC_W-1:0]     spc_ff;
   logic [RSV_W-1:0]     rsv_ff;
   logic [COPIES_W-1:0]  copies_ff;
   logic [FATSZ_W-1:0]   fatsz_ff;
   logic [ROOTENT_W-1:0] rootent_ff;

   // derived geometry
   logic [CB_W-1:0]      cb_ff;
   logic [FPROD_W-1:0]   fprod_ff;
   logic [AREA_W-1:0]    area_ff;
   logic [DSUM_W-1:0]    dsum_ff;
   logic [OFFSET_W-1:0]  root_start_ff;
   logic [OFFSET_W-1:0]  data_start_ff;
   logic [DIV_NUM_W-1:0] div_num;
   logic [DIV_NUM_W-1:0] div_q;
   logic [DIV_NUM_W-1:0] root_secs;
   logic                 div_done;
   logic [ROOTP_W-1:0]   root_prod;
   logic [DATAP_W-1:0]   data_prod;
   logic [LEN_W-1:0]     root_len;

   // chain state
   logic [CLUSTER_W-1:0] cluster_ff;
   logic [COUNT_W-1:0]   rem_ff;
   logic [OFFSET_W-1:0]  dest_ff;
   logic                 active_ff;
   logic [OFFSET_W-1:0]  prod_ff;
   logic [LEN_W-1:0]     len_ff;
   logic                 lo_ok_ff;
   logic                 hi_ok_ff;
   logic                 at_odd_ff;

   // table lookup
   logic [INDEX_W-1:0]   at;
   logic [INDEX_W:0]     at_hi;
   logic [INDEX_W-1:0]   half;
   logic [INDEX_W-1:0]   half_p1;
   logic                 wr_idx_ok;
   logic [BAW-1:0]       wr_addr;
   logic [BAW-1:0]       even_rd_addr;
   logic [BAW-1:0]       odd_rd_addr;
   logic [BYTE_W-1:0]    even_q;
   logic [BYTE_W-1:0]    odd_q;
   logic [BYTE_W-1:0]    lo_byte;
   logic [BYTE_W-1:0]    hi_byte;
   logic [2*BYTE_W-1:0]  word;
   logic [2*BYTE_W-1:0]  word_sh;
   logic [CLUSTER_W-1:0] nxt;
   logic signed [CREL_W-1:0]  crel;
   logic signed [CPROD_W-1:0] cprod;
   logic [LEN_W-1:0]     len_in;
   logic [COUNT_W-1:0]   rem_in;
   logic                 chain_done;
   logic                 chain_bad;

   // output register
   logic                 rsp_valid_ff;
   logic                 o_valid_ff;
   logic [OFFSET_W-1:0]  o_offset_ff;
   logic [LEN_W-1:0]     o_len_ff;
   logic [OFFSET_W-1:0]  o_dest_ff;
   logic                 o_last_ff;
   logic                 o_bad_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         bps_ff     <= BPS_RST;
         spc_ff     <= SPC_RST;
         rsv_ff     <= RSV_RST;
         copies_ff  <= COPIES_RST;
         fatsz_ff   <= FATSZ_RST;
         rootent_ff <= ROOTENT_RST;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_BPS:     bps_ff     <= csr_wdata[BPS_W-1:0];
            CSR_SPC:     spc_ff     <= csr_wdata[SPC_W-1:0];
            CSR_RSV:     rsv_ff     <= csr_wdata[RSV_W-1:0];
            CSR_COPIES:  copies_ff  <= csr_wdata[COPIES_W-1:0];
            CSR_FATSZ:   fatsz_ff   <= csr_wdata[FATSZ_W-1:0];
            CSR_ROOTENT: rootent_ff <= csr_wdata[ROOTENT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // ceil(root_entries * 32 / bytes_per_sector)
   assign div_num   = DIV_NUM_W'({rootent_ff, 5'b0}) + DIV_NUM_W'(bps_ff) - DIV_NUM_W'(1);
   assign root_secs = (bps_ff == '0) ? '0 : div_q;
   assign root_prod = ROOTP_W'(area_ff) * ROOTP_W'(bps_ff);
   assign data_prod = DATAP_W'(dsum_ff) * DATAP_W'(bps_ff);
   assign root_len  = LEN_W'({rootent_ff, 5'b0});

   fcr_div #(
      .NUM_W (DIV_NUM_W),
      .DEN_W (BPS_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.calc_prep),
      .dividend (div_num),
      .divisor  (bps_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   always_ff @(posedge clock) begin
      if (cmd.calc_prep) begin
         cb_ff    <= CB_W'(spc_ff) * CB_W'(bps_ff);
         fprod_ff <= FPROD_W'(copies_ff) * FPROD_W'(fatsz_ff);
      end
      if (cmd.calc_area) begin
         area_ff <= AREA_W'(rsv_ff) + AREA_W'(fprod_ff);
      end
      if (cmd.calc_scale) begin
         root_start_ff <= root_prod[OFFSET_W-1:0];
         dsum_ff       <= DSUM_W'(area_ff) + DSUM_W'(root_secs);
      end
      if (cmd.calc_data) begin
         data_start_ff <= data_prod[OFFSET_W-1:0];
      end
   end

   // table store split into even and odd byte banks: one read gets both bytes
   assign wr_idx_ok = 32'(table_byte_index) < 32'(TABLE_BYTES);
   assign wr_addr   = BAW'(table_byte_index >> 1);

   assign at           = INDEX_W'(cluster_ff) + INDEX_W'(cluster_ff >> 1);
   assign at_hi        = (INDEX_W + 1)'(at) + (INDEX_W + 1)'(1);
   assign half         = at >> 1;
   assign half_p1      = half + INDEX_W'(1);
   assign even_rd_addr = at[0] ? BAW'(half_p1) : BAW'(half);
   assign odd_rd_addr  = BAW'(half);

   fcr_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (BANK_DEPTH)
   ) u_even_bank (
      .clock   (clock),
      .wr_en   (cmd.table_write && wr_idx_ok && !table_byte_index[0]),
      .wr_addr (wr_addr),
      .wr_data (table_byte_value),
      .rd_en   (cmd.look),
      .rd_addr (even_rd_addr),
      .rd_data (even_q)
   );

   fcr_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (BANK_DEPTH)
   ) u_odd_bank (
      .clock   (clock),
      .wr_en   (cmd.table_write && wr_idx_ok && table_byte_index[0]),
      .wr_addr (wr_addr),
      .wr_data (table_byte_value),
      .rd_en   (cmd.look),
      .rd_addr (odd_rd_addr),
      .rd_data (odd_q)
   );

   // bytes beyond the store read as zero
   assign lo_byte = (at_odd_ff ? odd_q : even_q) & {BYTE_W{lo_ok_ff}};
   assign hi_byte = (at_odd_ff ? even_q : odd_q) & {BYTE_W{hi_ok_ff}};
   assign word    = {hi_byte, lo_byte};
   assign word_sh = cluster_ff[0] ? (word >> 4) : word;
   assign nxt     = word_sh[CLUSTER_W-1:0];

   // (cluster - 2) * cluster_bytes, wrapping for clusters 0 and 1
   assign crel   = $signed({1'b0, cluster_ff} - CREL_W'(2));
   assign cprod  = crel * $signed({1'b0, cb_ff});
   assign len_in = (rem_ff < COUNT_W'(cb_ff)) ? rem_ff[LEN_W-1:0] : cb_ff;

   assign rem_in     = rem_ff - COUNT_W'(len_ff);
   assign chain_bad  = (nxt == ENTRY_BAD);
   assign chain_done = (nxt >= ENTRY_BAD) || (rem_in == '0);

   always_ff @(posedge clock) begin
      if (cmd.look) begin
         prod_ff   <= cprod[OFFSET_W-1:0];
         len_ff    <= len_in;
         lo_ok_ff  <= 32'(at) < 32'(TABLE_BYTES);
         hi_ok_ff  <= 32'(at_hi) < 32'(TABLE_BYTES);
         at_odd_ff <= at[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cluster_ff <= '0;
         rem_ff     <= '0;
         dest_ff    <= '0;
         active_ff  <= 1'b0;
      end else if (cmd.chain_start) begin
         cluster_ff <= start_cluster;
         rem_ff     <= byte_count;
         dest_ff    <= '0;
         active_ff  <= 1'b1;
      end else if (cmd.emit && cmd.kind == RES_CHAIN) begin
         cluster_ff <= nxt;
         rem_ff     <= rem_in;
         dest_ff    <= dest_ff + OFFSET_W'(len_ff);
         if (chain_done) begin
            active_ff <= 1'b0;
         end
      end else if (cmd.emit && cmd.kind == RES_ROOT) begin
         // root directory read drops any chain in progress
         active_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         case (cmd.kind)
            RES_ROOT: begin
               o_valid_ff  <= 1'b1;
               o_offset_ff <= root_start_ff;
               o_len_ff    <= root_len;
               o_dest_ff   <= '0;
               o_last_ff   <= 1'b1;
               o_bad_ff    <= 1'b0;
            end
            RES_CHAIN: begin
               o_valid_ff  <= 1'b1;
               o_offset_ff <= prod_ff + data_start_ff;
               o_len_ff    <= len_ff;
               o_dest_ff   <= dest_ff;
               o_last_ff   <= chain_done;
               o_bad_ff    <= chain_bad;
            end
            default: begin
               o_valid_ff  <= 1'b0;
               o_offset_ff <= '0;
               o_len_ff    <= '0;
               o_dest_ff   <= '0;
               o_last_ff   <= 1'b0;
               o_bad_ff    <= 1'b0;
            end
         endcase
      end
   end

   assign st.op         = fcr_op_type'(opcode);
   assign st.start_zero = (start_cluster == '0);
   assign st.active     = active_ff;
   assign st.div_done   = div_done;
   assign st.out_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid     = rsp_valid_ff;
   assign request_valid = o_valid_ff;
   assign device_offset = o_offset_ff;
   assign read_length   = o_len_ff;
   assign dest_offset   = o_dest_ff;
   assign last          = o_last_ff;
   assign bad_cluster   = o_bad_ff;

endmodule

FILE: hw/rtl/fat12_cluster_chain_reader_core.sv
// FAT12 chain reader top level: stream ports, register port, controller
// and datapath. Uses fcr_pkg, fcr_ctrl and fcr_dp.
//
// Turns reads of FAT12 files into device read requests. Load the allocation
// table bytes first (opcode 0), then start a read (opcode 1) with a first
// cluster and byte count, and pull further requests with opcode 2; every
// request gives exactly one result, with request_valid low when nothing is
// issued. A chain request steps through accept, table read plus cluster
// offset multiply and emit; every other request goes from accept straight to
// emit. The next request is accepted once the result sits in the output
// register, even if it has not been taken. After reset and after any
// register write the block recomputes the disk geometry before taking a
// request, using the one-bit-per-cycle divider for the root directory
// sector count. Register writes are always accepted. Table bytes that were
// never loaded read back as unknown values.
module fat12_cluster_chain_reader_core #(
   parameter int TABLE_BYTES = fcr_pkg::TABLE_BYTES_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // req_tdata: table_byte_index[12:0], table_byte_value[20:13],
   //            start_cluster[32:21], byte_count[64:33], zero pad
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [fcr_pkg::REQ_TDATA_W-1:0]      req_tdata,
   // req_tuser: opcode[1:0]
   input  logic [fcr_pkg::OP_W-1:0]             req_tuser,
   // rsp_tdata: device_offset[31:0], read_length[52:32],
   //            dest_offset[84:53], zero pad
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [fcr_pkg::RSP_TDATA_W-1:0]      rsp_tdata,
   // rsp_tuser: request_valid[0], bad_cluster[1]
   output logic [fcr_pkg::RSP_TUSER_W-1:0]      rsp_tuser,
   output logic                                 rsp_tlast,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [fcr_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [fcr_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   import fcr_pkg::*;

   localparam int RSP_PAD_W = RSP_TDATA_W - (2 * OFFSET_W + LEN_W);

   fcr_cmd_type          cmd;
   fcr_status_type       st;
   logic                 csr_write;
   logic                 request_valid;
   logic [OFFSET_W-1:0]  device_offset;
   logic [LEN_W-1:0]     read_length;
   logic [OFFSET_W-1:0]  dest_offset;
   logic                 bad_cluster;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   fcr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .csr_write  (csr_write),
      .st         (st),
      .cmd        (cmd)
   );

   fcr_dp #(
      .TABLE_BYTES (TABLE_BYTES)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .st               (st),
      .opcode           (req_tuser),
      .table_byte_index (req_tdata[INDEX_W-1:0]),
      .table_byte_value (req_tdata[INDEX_W +: BYTE_W]),
      .start_cluster    (req_tdata[INDEX_W + BYTE_W +: CLUSTER_W]),
      .byte_count       (req_tdata[INDEX_W + BYTE_W + CLUSTER_W +: COUNT_W]),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .rsp_ready        (rsp_tready),
      .rsp_valid        (rsp_tvalid),
      .request_valid    (request_valid),
      .device_offset    (device_offset),
      .read_length      (read_length),
      .dest_offset      (dest_offset),
      .last             (rsp_tlast),
      .bad_cluster      (bad_cluster)
   );

   assign rsp_tdata = {{RSP_PAD_W{1'b0}}, dest_offset, read_length, device_offset};
   assign rsp_tuser = {bad_cluster, request_valid};

endmodule
